// ----- src/assert_macros.svh -----
// Assertion macros shared by the RTL files of the random source.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Implication checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NEVER(label, clk, rst, cond, msg)
`endif
`endif

// ----- src/lcgr_pkg.sv -----
// Package of the random source: constants, sequencer states and status types.
package lcgr_pkg;

  localparam int unsigned STATE_W = 32;
  localparam int unsigned HALF_W  = 16;
  localparam int unsigned CNT_W   = $clog2(HALF_W + 1);

  localparam logic [STATE_W-1:0] LCG_MUL     = 32'd1103512986;
  localparam logic [STATE_W-1:0] LCG_ADD     = 32'd29865;
  localparam logic [STATE_W-1:0] RANGE_RESET = 32'd16777215;
  localparam logic [STATE_W-1:0] STATE_RESET = 32'd1;
  localparam logic [CNT_W-1:0]   DIV_STEPS   = CNT_W'(HALF_W);

  // Request codes.
  localparam logic REQ_DRAW   = 1'b0;
  localparam logic REQ_RESEED = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_DIV
  } seq_state_t;

  // Status of the remainder unit.
  typedef struct packed {
    logic busy;
    logic done;
  } rem_stat_t;

endpackage

// ----- src/lcgr_req_if.sv -----
// Request channel: draw or reseed items.
interface lcgr_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [31:0] seed_value;

  modport source (output valid, output req_type, output seed_value, input ready);
  modport sink (input valid, input req_type, input seed_value, output ready);
endinterface

// ----- src/lcgr_rsp_if.sv -----
// Response channel: one random value per draw.
interface lcgr_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] random_value;

  modport source (output valid, output random_value, input ready);
  modport sink (input valid, input random_value, output ready);
endinterface

// ----- src/lcg_random_with_range.sv -----
// Top level of the range-limited linear congruential random source.
// A draw item passes through the 32-bit multiply, the add, and sixteen steps
// of the shared subtract-and-compare unit that reduces the upper half of the
// new state modulo range_max + 1, and then loads the output register. When
// range_max is 65536 or more the reduction is skipped. A reseed item gives no
// result. The block takes one item at a time; a finished value waits in the
// output register while the next item is accepted. The user must write
// range_max through cfg_we/cfg_wdata only while the block is idle; the block
// itself does not enforce this.
`include "assert_macros.svh"

module lcg_random_with_range (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lcgr_pkg::STATE_W-1:0] cfg_wdata,
  lcgr_req_if.sink                     req,
  lcgr_rsp_if.source                   rsp
);
  import lcgr_pkg::*;

  seq_state_t          state;
  seq_state_t          state_next;
  logic [STATE_W-1:0]  range_max;
  logic [STATE_W-1:0]  gen_state;
  logic [STATE_W-1:0]  prod;
  logic [STATE_W-1:0]  sum;
  logic                rsp_valid;
  logic [HALF_W-1:0]   rsp_value;
  logic                div_start;
  logic                load_rsp;
  logic                req_acc;
  rem_stat_t           rem_stat;
  logic [HALF_W-1:0]   rem_value;

  assign req_acc = req.valid && req.ready;
  assign sum     = prod + LCG_ADD;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      range_max <= RANGE_RESET;
    end else if (cfg_we) begin
      range_max <= cfg_wdata;
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and control.
  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    load_rsp   = 1'b0;
    req.ready  = 1'b0;
    unique case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid && (req.req_type == REQ_DRAW)) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ADD;
      end
      S_ADD: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (rem_stat.done && (!rsp_valid || rsp.ready)) begin
          load_rsp   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Generator state: reseed on request, advance after the multiply.
  always_ff @(posedge clk) begin
    if (rst) begin
      gen_state <= STATE_RESET;
    end else if (req_acc && (req.req_type == REQ_RESEED)) begin
      gen_state <= req.seed_value;
    end else if (state == S_ADD) begin
      gen_state <= sum;
    end
  end

  // Product register, truncated to the state width.
  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= gen_state * LCG_MUL;
    end
  end

  lcgr_rem u_rem (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (sum[STATE_W-1:HALF_W]),
    .limit     (range_max),
    .stat      (rem_stat),
    .remainder (rem_value)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_value <= rem_value;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.random_value = rsp_value;

  // A draw moves the sequencer to the multiply step.
  `ASSERT_CLK(a_draw_mul, clk, rst, (req_acc && (req.req_type == REQ_DRAW)) |=> (state == S_MUL), "draw did not start multiply")
  // A reseed loads the seed into the generator state.
  `ASSERT_CLK(a_reseed, clk, rst, (req_acc && (req.req_type == REQ_RESEED)) |=> (gen_state == $past(req.seed_value)), "reseed not loaded")
  // The remainder unit is idle whenever new items are taken.
  `ASSERT_NEVER(a_idle_busy, clk, rst, (state == S_IDLE) && rem_stat.busy, "remainder busy while idle")

endmodule

// ----- src/lcgr_rem.sv -----
// Iterative restoring remainder unit: 16-bit dividend modulo (limit + 1).
`include "assert_macros.svh"

module lcgr_rem (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [lcgr_pkg::HALF_W-1:0]   dividend,
  input  logic [lcgr_pkg::STATE_W-1:0]  limit,
  output lcgr_pkg::rem_stat_t           stat,
  output logic [lcgr_pkg::HALF_W-1:0]   remainder
);
  import lcgr_pkg::*;

  logic [CNT_W-1:0]  cnt;
  logic [HALF_W-1:0] shreg;
  logic [HALF_W:0]   rem;
  logic [HALF_W:0]   divisor;
  logic              busy;
  logic              done;
  logic              bypass;
  logic [HALF_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and compare.
  assign trial = {rem[HALF_W-1:0], shreg[HALF_W-1]};
  assign fits  = (trial >= divisor);

  // A limit of 65536 or more leaves every 16-bit value untouched,
  // which also covers the full 32-bit limit.
  assign bypass = (limit[STATE_W-1:HALF_W] != '0);

  // Sequencer of the shared subtract-and-compare step.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      if (bypass) begin
        busy <= 1'b0;
        done <= 1'b1;
        cnt  <= '0;
      end else begin
        busy <= 1'b1;
        done <= 1'b0;
        cnt  <= DIV_STEPS;
      end
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // Datapath of the remainder.
  always_ff @(posedge clk) begin
    if (start) begin
      shreg   <= dividend;
      divisor <= {1'b0, limit[HALF_W-1:0]} + 1'b1;
      if (bypass) begin
        rem <= {1'b0, dividend};
      end else begin
        rem <= '0;
      end
    end else if (busy) begin
      shreg <= {shreg[HALF_W-2:0], 1'b0};
      rem   <= fits ? (trial - divisor) : trial;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem[HALF_W-1:0];

  // The unit is never busy and done at once.
  `ASSERT_NEVER(a_busy_done, clk, rst, busy && done, "remainder unit busy and done")
  // While busy, a step count remains.
  `ASSERT_CLK(a_busy_cnt, clk, rst, busy |-> (cnt != '0), "busy with no steps left")

endmodule

// ----- dv/lcgr_checker.sv -----
`timescale 1ns / 1ps
// Checker for the random source: predicts every draw and compares it with the response channel.
module lcgr_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [lcgr_pkg::STATE_W-1:0] cfg_wdata,
  lcgr_req_if                          req_ch,
  lcgr_rsp_if                          rsp_ch,
  output int                           fail_count,
  output int                           pending_cnt
);
  import lcgr_pkg::*;

  // Shadow copy of the range register and of the generator state.
  logic [STATE_W-1:0] range_lim;
  logic [STATE_W-1:0] lcg_state;
  // Values that accepted draws are due to return, oldest first.
  logic [HALF_W-1:0]  pending_draws[$];
  int                 fails = 0;

  // One step of the generator, wrapping modulo 2^32.
  function automatic logic [STATE_W-1:0] next_lcg_state(logic [STATE_W-1:0] cur);
    return cur * LCG_MUL + LCG_ADD;
  endfunction

  // Reduce the upper half modulo limit + 1; the all-ones limit means no reduction.
  function automatic logic [HALF_W-1:0] fold_to_range(logic [HALF_W-1:0] hi,
                                                      logic [STATE_W-1:0] lim);
    logic [STATE_W:0] modulus;
    if (lim == '1) begin
      return hi;
    end
    modulus = {1'b0, lim} + 1'b1;
    return HALF_W'({17'b0, hi} % modulus);
  endfunction

  // Track configuration and requests, then match each accepted response.
  always @(posedge clk) begin
    logic [HALF_W-1:0] want;
    if (rst) begin
      range_lim = RANGE_RESET;
      lcg_state = STATE_RESET;
      pending_draws.delete();
    end else begin
      if (cfg_we) begin
        range_lim = cfg_wdata;
      end
      if (req_ch.valid && req_ch.ready) begin
        if (req_ch.req_type == REQ_RESEED) begin
          lcg_state = req_ch.seed_value;
        end else begin
          lcg_state = next_lcg_state(lcg_state);
          pending_draws.push_back(fold_to_range(lcg_state[STATE_W-1:HALF_W], range_lim));
        end
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (pending_draws.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual random_value %0d",
                   $time, rsp_ch.random_value);
          fails++;
        end else begin
          want = pending_draws.pop_front();
          if (rsp_ch.random_value !== want) begin
            $display("%0t: random_value mismatch, expected %0d, actual %0d",
                     $time, want, rsp_ch.random_value);
            fails++;
          end
        end
      end
    end
    fail_count  <= fails;
    pending_cnt <= pending_draws.size();
  end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top for the random source: clock, reset, stimulus, response stalls and verdict.
module tb_top;
  import lcgr_pkg::*;

  localparam int SETTLE_CYCLES  = 25;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_ITEMS   = 630;
  localparam logic [STATE_W-1:0] LIMIT_CORNERS [8] = '{
    32'd0, 32'd1, 32'd2, 32'd65534, 32'd65535, 32'd65536, 32'hFFFF_FFFE, 32'hFFFF_FFFF
  };

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [STATE_W-1:0] cfg_wdata;
  int                 fail_count;
  int                 pending_cnt;
  int                 stuck_cycles = 0;
  bit                 hold_req = 1'b0;

  lcgr_req_if req_ch ();
  lcgr_rsp_if rsp_ch ();

  lcg_random_with_range uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  lcgr_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .req_ch      (req_ch),
    .rsp_ch      (rsp_ch),
    .fail_count  (fail_count),
    .pending_cnt (pending_cnt)
  );

  always #6 clk = ~clk;

  // Offer one item and hold it until the block takes it.
  task automatic send_req(input logic kind, input logic [STATE_W-1:0] seed);
    req_ch.valid      <= 1'b1;
    req_ch.req_type   <= kind;
    req_ch.seed_value <= seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop offering, wait for every predicted value, then let a reseed settle.
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_cnt != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the range limit while the block is idle.
  task automatic write_range(input logic [STATE_W-1:0] lim);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Ready pattern of the receiver, with one long hold-off on request.
  initial begin : rsp_sink
    int mode;
    int dwell;
    int period;
    int tick;
    mode   = 0;
    dwell  = 0;
    period = 3;
    tick   = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        if (dwell == 0) begin
          mode   = $urandom_range(0, 3);
          dwell  = $urandom_range(20, 150);
          period = $urandom_range(2, 7);
        end
        dwell--;
        tick++;
        case (mode)
          0: rsp_ch.ready <= 1'b1;
          1: rsp_ch.ready <= 1'($urandom_range(0, 1));
          2: rsp_ch.ready <= (tick % period) != 0;
          default: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Timeout when nothing is accepted on either channel for too long.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Stimulus: directed corners first, then random phases with new limits.
  initial begin : stimulus
    int                 n_sent;
    int                 phase;
    int                 in_phase;
    int                 phase_len;
    int                 burst;
    int                 gap;
    bit                 no_gaps;
    logic               kind;
    logic [STATE_W-1:0] seed;
    logic [STATE_W-1:0] lim;

    rst               <= 1'b1;
    cfg_we            <= 1'b0;
    cfg_wdata         <= '0;
    req_ch.valid      <= 1'b0;
    req_ch.req_type   <= REQ_DRAW;
    req_ch.seed_value <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Draws from the reset state under the default limit; the seed field is ignored.
    send_req(REQ_DRAW, 32'hFFFF_FFFF);
    send_req(REQ_DRAW, 32'h0000_0000);
    // Reseeds with extreme seeds, each followed by a draw.
    send_req(REQ_RESEED, 32'h0000_0000);
    send_req(REQ_DRAW, 32'h1234_5678);
    send_req(REQ_RESEED, 32'hFFFF_FFFF);
    send_req(REQ_DRAW, 32'h0000_0000);
    send_req(REQ_RESEED, 32'h8000_0000);
    send_req(REQ_DRAW, 32'hFFFF_FFFF);
    // Back-to-back reseeds: the last one overwrites the first before the draw.
    send_req(REQ_RESEED, 32'hDEAD_BEEF);
    send_req(REQ_RESEED, 32'h0000_0001);
    send_req(REQ_DRAW, 32'hA5A5_A5A5);
    // Limit corners, including the zero limit and the full limit.
    foreach (LIMIT_CORNERS[i]) begin
      write_range(LIMIT_CORNERS[i]);
      send_req(REQ_DRAW, $urandom);
      send_req(REQ_DRAW, $urandom);
    end

    // Random phases, each under a fresh limit.
    n_sent = 0;
    phase  = 0;
    while (n_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       lim = '0;
        1, 2, 3: lim = $urandom_range(1, 300);
        4:       lim = $urandom_range(301, 65534);
        5:       lim = $urandom_range(65535, 32'hFFFF_FFFF);
        6:       lim = '1;
        default: lim = $urandom;
      endcase
      write_range(lim);
      // One phase keeps offering while the receiver holds off, so the block backs up.
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      no_gaps   = (phase == 2) || ($urandom_range(0, 3) == 0);
      phase_len = $urandom_range(30, 70);
      in_phase  = 0;
      while (in_phase < phase_len) begin
        burst = no_gaps ? phase_len : $urandom_range(1, 12);
        repeat (burst) begin
          kind = ($urandom_range(0, 99) < 15) ? REQ_RESEED : REQ_DRAW;
          case ($urandom_range(0, 9))
            0:       seed = '0;
            1:       seed = '1;
            default: seed = $urandom;
          endcase
          send_req(kind, seed);
          in_phase++;
        end
        if (!no_gaps) begin
          gap = $urandom_range(0, 20);
          if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
      end
      n_sent += in_phase;
      phase++;
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
